[hdl/sb5_pkg.sv]
// Shared types, constants and filter arithmetic for the separable 5x5 RGB blur.
// Depends on nothing; the core and the testbench import it.
package sb5_pkg;

   localparam int CSR_WIDTH = 11;
   localparam logic [CSR_WIDTH-1:0] RESET_WIDTH  = 11'd640;
   localparam logic [CSR_WIDTH-1:0] RESET_HEIGHT = 11'd480;

   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   localparam logic ACTION_PIXEL = 1'b0;
   localparam logic ACTION_DRAIN = 1'b1;

   // s / 10 == (s * 1639) >> 14 for every s below 2730
   localparam logic [10:0] DIV_MULT  = 11'd1639;
   localparam int          DIV_SHIFT = 14;

   localparam int OQ_DEPTH = 8;
   localparam int OQ_AW    = 3;
   localparam int OQ_LIMIT = OQ_DEPTH - 5;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pix_type;

   typedef pix_type [4:0] taps_type;
   typedef pix_type [3:0] line_type;

   typedef struct packed {
      logic valid;
      logic drain;
      logic last_row;
      logic top;
      logic emit;
      logic row_end;
      logic frame_end;
   } job_type;

   typedef struct packed {
      pix_type pix;
      logic    row_end;
      logic    frame_end;
   } result_type;

   function automatic logic [7:0] chan_filt(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c, input logic [7:0] d,
                                            input logic [7:0] e);
      logic [11:0] s;
      logic [22:0] p;
      s = 12'(a) + 12'({b, 1'b0}) + 12'({c, 2'b00}) + 12'({d, 1'b0}) + 12'(e);
      p = 23'(s) * 23'(DIV_MULT);
      return p[DIV_SHIFT+7:DIV_SHIFT];
   endfunction

   function automatic pix_type filt5(input taps_type p);
      pix_type r;
      r.blue  = chan_filt(p[0].blue,  p[1].blue,  p[2].blue,  p[3].blue,  p[4].blue);
      r.green = chan_filt(p[0].green, p[1].green, p[2].green, p[3].green, p[4].green);
      r.red   = chan_filt(p[0].red,   p[1].red,   p[2].red,   p[3].red,   p[4].red);
      return r;
   endfunction

endpackage

[hdl/sb5_stream_if.sv]
// Valid/ready stream interfaces for the blur's request and result channels.
// Plain signals only; no dependency on the package.
interface sb5_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] blue_in;
   logic [7:0] green_in;
   logic [7:0] red_in;
   modport source (output valid, action, blue_in, green_in, red_in, input ready);
   modport sink   (input valid, action, blue_in, green_in, red_in, output ready);
endinterface

interface sb5_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] blue_out;
   logic [7:0] green_out;
   logic [7:0] red_out;
   logic       row_end;
   logic       frame_end;
   modport source (output valid, blue_out, green_out, red_out, row_end, frame_end,
                   input ready);
   modport sink   (input valid, blue_out, green_out, red_out, row_end, frame_end,
                   output ready);
endinterface

[hdl/separable_blur_5x5_rgb_core.sv]
// Top level of the separable 5x5 RGB blur: horizontal window, line memory, result queue.
// Depends on sb5_pkg and the stream interfaces in sb5_stream_if.sv.
//
// Usage: send pixels of a frame in raster order on req_stream with action = pixel;
// after the frame's last pixel, send drain requests (action = drain), one per result, to
// release the last two rows (one if height 1). frame_end marks the frame's final result;
// a drain with nothing pending gives no result. csr_write sets frame_width (index 0) or
// frame_height (index 1) and restarts the frame; write only while the block is idle.
// Order: a request's job passes job_ff and s2_ff and is pushed into the result queue,
// which drives rsp_stream; a row end's one or two extra results enter it one per cycle.
// Throughput: one request per clock while at most three results wait; after each row's
// last pixel ready stays low while the last two columns go through the line memory,
// which takes one column read-modify-write per cycle on its single read and write port.
// Reset: sizes return to 640 x 480, positions to zero; the line memory is not cleared,
// row 0 of every frame fills it. No clearing pass.
// Stall: results wait in an 8-entry queue; ready drops while more than three wait.
module separable_blur_5x5_rgb_core #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   sb5_req_if.sink                        req_stream,
   sb5_rsp_if.source                      rsp_stream,
   input  logic                           csr_write,
   input  logic                           csr_index,
   input  logic [sb5_pkg::CSR_WIDTH-1:0]  csr_wdata
);
   import sb5_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_FIRST  = 2'd1;
   localparam logic [1:0] PH_SECOND = 2'd2;

   logic [CSR_WIDTH-1:0] width_ff, width_in, height_ff, height_in;
   logic [CW-1:0]        wlast;
   logic [RW-1:0]        hlast;

   logic [CW-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in, flush_col_ff, flush_col_in;
   logic [RW-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in, flush_row_ff, flush_row_in;
   logic          draining_ff, draining_in;
   logic [1:0]    phase_ff, phase_in;
   taps_type      window_ff, window_in;

   logic          req_accept, pixel_acc, drain_acc, job_gen;
   pix_type       px;
   logic [CW-1:0] c_eff;
   logic [RW-1:0] r_eff, job_row;

   job_type       job_ff, job_in;
   logic [CW-1:0] jcol_ff, jcol_in;
   pix_type       jhv_ff, jhv_in;

   line_type      line_mem [MAX_WIDTH];
   line_type      rd_ff, fwd_data_ff, entry, wr_entry;
   logic          fwd_ff, s2_wr;

   job_type       s2_ff;
   logic [CW-1:0] s2col_ff;
   pix_type       s2hv_ff;
   taps_type      taps;
   pix_type       vres;

   result_type     oq_ff [OQ_DEPTH];
   logic [OQ_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [OQ_AW:0]   count_ff;
   logic             push, pop;
   result_type       head;

   always_comb begin
      if (width_ff == '0) begin
         wlast = '0;
      end else if (32'(width_ff) > MAX_WIDTH) begin
         wlast = CW'(MAX_WIDTH - 1);
      end else begin
         wlast = CW'(width_ff - 1'b1);
      end
      if (height_ff == '0) begin
         hlast = '0;
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         hlast = RW'(MAX_HEIGHT - 1);
      end else begin
         hlast = RW'(height_ff - 1'b1);
      end
   end

   assign req_stream.ready = (phase_ff == PH_IDLE) && (count_ff <= (OQ_AW+1)'(OQ_LIMIT));
   assign req_accept = req_stream.valid && req_stream.ready;
   assign pixel_acc  = req_accept && (req_stream.action == ACTION_PIXEL);
   assign drain_acc  = req_accept && (req_stream.action == ACTION_DRAIN);
   assign px    = '{red: req_stream.red_in, green: req_stream.green_in,
                    blue: req_stream.blue_in};
   assign c_eff = draining_ff ? '0 : in_col_ff;
   assign r_eff = draining_ff ? '0 : in_row_ff;

   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      in_col_in    = in_col_ff;
      in_row_in    = in_row_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      draining_in  = draining_ff;
      phase_in     = phase_ff;
      flush_col_in = flush_col_ff;
      flush_row_in = flush_row_ff;
      window_in    = window_ff;
      job_in       = '0;
      jcol_in      = jcol_ff;
      jhv_in       = jhv_ff;
      job_row      = '0;
      job_gen      = 1'b0;
      priority if (csr_write) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  width_in  = csr_wdata;
            REG_FRAME_HEIGHT: height_in = csr_wdata;
         endcase
         in_col_in   = '0;
         in_row_in   = '0;
         out_col_in  = '0;
         out_row_in  = '0;
         draining_in = 1'b0;
      end else if (phase_ff == PH_FIRST) begin
         window_in = {window_ff[4], window_ff[4:1]};
         phase_in  = PH_SECOND;
         job_row   = flush_row_ff;
         if (flush_col_ff != '0) begin
            job_gen = 1'b1;
            jcol_in = flush_col_ff - 1'b1;
         end
      end else if (phase_ff == PH_SECOND) begin
         window_in = {window_ff[4], window_ff[4:1]};
         phase_in  = PH_IDLE;
         job_row   = flush_row_ff;
         job_gen   = 1'b1;
         jcol_in   = flush_col_ff;
      end else if (pixel_acc) begin
         // drop any pending drain; this pixel starts a new frame
         if (draining_ff) begin
            out_col_in  = '0;
            out_row_in  = '0;
            draining_in = 1'b0;
         end
         in_row_in = r_eff;
         window_in = (c_eff == '0) ? {5{px}} : {px, window_ff[4:1]};
         job_row   = r_eff;
         if (c_eff >= CW'(2)) begin
            job_gen = 1'b1;
            jcol_in = c_eff - CW'(2);
         end
         if (c_eff == wlast) begin
            phase_in     = PH_FIRST;
            flush_col_in = c_eff;
            flush_row_in = r_eff;
            in_col_in    = '0;
            if (r_eff == hlast) begin
               in_row_in   = '0;
               out_row_in  = (hlast != '0) ? hlast - 1'b1 : '0;
               out_col_in  = '0;
               draining_in = 1'b1;
            end else begin
               in_row_in = r_eff + 1'b1;
            end
         end else begin
            in_col_in = c_eff + 1'b1;
         end
      end else if (drain_acc && draining_ff) begin
         job_in.valid     = 1'b1;
         job_in.drain     = 1'b1;
         job_in.emit      = 1'b1;
         job_in.last_row  = (out_row_ff == hlast);
         job_in.row_end   = (out_col_ff == wlast);
         job_in.frame_end = job_in.row_end && job_in.last_row;
         jcol_in          = out_col_ff;
         if (job_in.frame_end) begin
            in_col_in   = '0;
            in_row_in   = '0;
            out_col_in  = '0;
            out_row_in  = '0;
            draining_in = 1'b0;
         end else if (job_in.row_end) begin
            out_col_in = '0;
            out_row_in = out_row_ff + 1'b1;
         end else begin
            out_col_in = out_col_ff + 1'b1;
         end
      end
      if (job_gen) begin
         job_in.valid   = 1'b1;
         job_in.top     = (job_row == '0);
         job_in.emit    = (job_row >= RW'(2));
         job_in.row_end = (jcol_in == wlast);
         jhv_in         = filt5(window_in);
      end
   end

   // vertical pass: four stored rows (newest entry[0]) and, unless draining, the new row
   always_comb begin
      entry = fwd_ff ? fwd_data_ff : rd_ff;
      priority if (s2_ff.drain && s2_ff.last_row) begin
         taps = {entry[0], entry[0], entry[0], entry[1], entry[2]};
      end else if (s2_ff.drain) begin
         taps = {entry[0], entry[0], entry[1], entry[2], entry[3]};
      end else begin
         taps = {s2hv_ff, entry[0], entry[1], entry[2], entry[3]};
      end
      wr_entry = s2_ff.top ? {4{s2hv_ff}} : {entry[2], entry[1], entry[0], s2hv_ff};
   end

   assign vres  = filt5(taps);
   assign s2_wr = s2_ff.valid && !s2_ff.drain;
   assign push  = s2_ff.valid && s2_ff.emit;
   assign pop   = rsp_stream.valid && rsp_stream.ready;
   assign head  = oq_ff[rd_ptr_ff];

   assign rsp_stream.valid     = (count_ff != '0);
   assign rsp_stream.blue_out  = head.pix.blue;
   assign rsp_stream.green_out = head.pix.green;
   assign rsp_stream.red_out   = head.pix.red;
   assign rsp_stream.row_end   = head.row_end;
   assign rsp_stream.frame_end = head.frame_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= RESET_WIDTH;
         height_ff   <= RESET_HEIGHT;
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         draining_ff <= 1'b0;
         phase_ff    <= PH_IDLE;
         job_ff      <= '0;
         s2_ff       <= '0;
         fwd_ff      <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         draining_ff <= draining_in;
         phase_ff    <= phase_in;
         job_ff      <= job_in;
         s2_ff       <= job_ff;
         fwd_ff      <= s2_wr && job_ff.valid && (s2col_ff == jcol_ff);
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      window_ff    <= window_in;
      flush_col_ff <= flush_col_in;
      flush_row_ff <= flush_row_in;
      jcol_ff      <= jcol_in;
      jhv_ff       <= jhv_in;
      s2col_ff     <= jcol_ff;
      s2hv_ff      <= jhv_ff;
      fwd_data_ff  <= wr_entry;
      if (push) begin
         oq_ff[wr_ptr_ff] <= '{pix: vres, row_end: s2_ff.row_end, frame_end: s2_ff.frame_end};
      end
   end

   always_ff @(posedge clock) begin
      if (s2_wr) begin
         line_mem[s2col_ff] <= wr_entry;
      end
      if (job_ff.valid) begin
         rd_ff <= line_mem[jcol_ff];
      end
   end

   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && (count_ff == (OQ_AW+1)'(OQ_DEPTH))))
      else $error("result queue overflow");

   a_flush_row_end: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SECOND && !csr_write) |=> (job_ff.valid && job_ff.row_end))
      else $error("row-end flush did not issue the last column");

   a_forward_live: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> s2_ff.valid)
      else $error("forwarded entry without a job in the second stage");

   a_frame_end_row_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_stream.valid && rsp_stream.frame_end) |-> rsp_stream.row_end)
      else $error("frame end without row end");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for separable_blur_5x5_rgb_core: random and directed frames in,
// blurred pixels checked against an in-bench filter model. Needs sb5_pkg and sb5_stream_if.
module testbench;
   import sb5_pkg::*;

   localparam int LINE_MAX    = 1024;
   localparam int STUCK_LIMIT = 5000;
   localparam int LONG_HOLD   = 300;

   typedef struct packed {
      logic    action;
      pix_type px;
   } blur_req_type;

   logic clock;
   logic reset;
   logic csr_write;
   logic csr_index;
   logic [CSR_WIDTH-1:0] csr_wdata;

   sb5_req_if req_if ();
   sb5_rsp_if rsp_if ();

   separable_blur_5x5_rgb_core #(
      .MAX_WIDTH  (LINE_MAX),
      .MAX_HEIGHT (LINE_MAX)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_if),
      .rsp_stream (rsp_if),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // filter model state
   logic [CSR_WIDTH-1:0] width_reg;
   logic [CSR_WIDTH-1:0] height_reg;
   taps_type    win;
   pix_type     lines [4*LINE_MAX];
   int unsigned col_in, row_in, col_out, row_out;
   bit          draining;
   result_type  blur_expected [$];

   blur_req_type req_pending [$];
   logic req_fire, rsp_fire;
   int   send_gap, recv_gap, long_hold_left;
   bit   send_quiet, recv_quiet, long_hold_done;
   int   mismatch_count;
   int   stuck_cycles;

   function automatic int unsigned size_in_use(input logic [CSR_WIDTH-1:0] v);
      if (v == 0) return 1;
      if (v > LINE_MAX) return LINE_MAX;
      return 32'(v);
   endfunction

   function automatic logic [7:0] tap_sum(input int a, input int b, input int c,
                                          input int d, input int e);
      return 8'((a + 2*b + 4*c + 2*d + e) / 10);
   endfunction

   function automatic pix_type blur5(input taps_type t);
      pix_type r;
      r.blue  = tap_sum(t[0].blue,  t[1].blue,  t[2].blue,  t[3].blue,  t[4].blue);
      r.green = tap_sum(t[0].green, t[1].green, t[2].green, t[3].green, t[4].green);
      r.red   = tap_sum(t[0].red,   t[1].red,   t[2].red,   t[3].red,   t[4].red);
      return r;
   endfunction

   // vertical pass; cur_row < 0 means every tap comes from the line store
   function automatic pix_type column_blur(input int orow, input int unsigned x,
                                           input int cur_row, input pix_type cur,
                                           input int unsigned h);
      taps_type t;
      int r;
      for (int k = 0; k < 5; k++) begin
         r = orow + k - 2;
         if (r < 0) r = 0;
         if (r > int'(h) - 1) r = int'(h) - 1;
         t[k] = (r == cur_row) ? cur : lines[(r % 4) * LINE_MAX + x];
      end
      return blur5(t);
   endfunction

   task automatic restart_frame();
      col_in   = 0;
      row_in   = 0;
      col_out  = 0;
      row_out  = 0;
      draining = 1'b0;
   endtask

   task automatic add_expected(input result_type res);
      blur_expected.insert(blur_expected.size(), res);
   endtask

   task automatic finish_column(input int unsigned r, input int unsigned x,
                                input int unsigned w, input int unsigned h);
      pix_type    hv;
      result_type res;
      hv = blur5(win);
      if (r >= 2) begin
         res.pix       = column_blur(int'(r) - 2, x, int'(r), hv, h);
         res.row_end   = (x == w - 1);
         res.frame_end = 1'b0;
         add_expected(res);
      end
      lines[(r % 4) * LINE_MAX + x] = hv;
   endtask

   task automatic blur_predict(input logic act, input pix_type px);
      int unsigned w, h, c, r;
      result_type  res;
      w = size_in_use(width_reg);
      h = size_in_use(height_reg);
      if (act == ACTION_DRAIN) begin
         if (draining) begin
            res.pix       = column_blur(int'(row_out), col_out, -1, '0, h);
            res.row_end   = (col_out == w - 1);
            res.frame_end = res.row_end && (row_out == h - 1);
            add_expected(res);
            if (res.frame_end) begin
               restart_frame();
            end else if (res.row_end) begin
               col_out = 0;
               row_out++;
            end else begin
               col_out++;
            end
         end
      end else begin
         if (draining) restart_frame();
         c = col_in;
         r = row_in;
         if (c == 0) win = {5{px}};
         else win = {px, win[4:1]};
         if (c >= 2) finish_column(r, c - 2, w, h);
         if (c == w - 1) begin
            win = {win[4], win[4:1]};
            if (c >= 1) finish_column(r, c - 1, w, h);
            win = {win[4], win[4:1]};
            finish_column(r, c, w, h);
            col_in = 0;
            if (r == h - 1) begin
               row_in   = 0;
               row_out  = (h >= 2) ? h - 2 : 0;
               col_out  = 0;
               draining = 1'b1;
            end else begin
               row_in = r + 1;
            end
         end else begin
            col_in = c + 1;
         end
      end
   endtask

   function automatic int draw_wait(inout bit quiet);
      if ($urandom_range(0, 31) == 0) quiet = !quiet;
      return quiet ? 0 : $urandom_range(0, 5);
   endfunction

   function automatic pix_type rand_pix();
      return pix_type'(24'($urandom));
   endfunction

   // request side
   always @(posedge clock) begin
      req_fire <= !reset && req_if.valid && req_if.ready;
      if (!reset && req_if.valid && req_if.ready) begin
         blur_predict(req_if.action, {req_if.red_in, req_if.green_in, req_if.blue_in});
         void'(req_pending.pop_front());
      end
   end

   always @(negedge clock) begin
      if (!reset && (!req_if.valid || req_fire)) begin
         if (req_fire) send_gap = draw_wait(send_quiet);
         if (send_gap > 0) begin
            send_gap--;
            req_if.valid <= 1'b0;
         end else if (req_pending.size() > 0) begin
            req_if.valid    <= 1'b1;
            req_if.action   <= req_pending[0].action;
            req_if.blue_in  <= req_pending[0].px.blue;
            req_if.green_in <= req_pending[0].px.green;
            req_if.red_in   <= req_pending[0].px.red;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // result side
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_fire) recv_gap = draw_wait(recv_quiet);
         // hold off once while a long backlog waits, so the block fills and stalls
         if (!long_hold_done && req_pending.size() >= 32) begin
            long_hold_left = LONG_HOLD;
            long_hold_done = 1'b1;
         end
         if (long_hold_left > 0) begin
            long_hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      rsp_fire <= !reset && rsp_if.valid && rsp_if.ready;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (blur_expected.size() == 0) begin
            $error("result with no pixel expected");
            mismatch_count++;
         end else begin
            want = blur_expected.pop_front();
            check_field("blue_out",  want.pix.blue,  rsp_if.blue_out);
            check_field("green_out", want.pix.green, rsp_if.green_out);
            check_field("red_out",   want.pix.red,   rsp_if.red_out);
            check_field("row_end",   8'(want.row_end),   8'(rsp_if.row_end));
            check_field("frame_end", 8'(want.frame_end), 8'(rsp_if.frame_end));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   task automatic queue_req(input logic act, input pix_type px);
      blur_req_type q;
      q.action = act;
      q.px     = px;
      req_pending.insert(req_pending.size(), q);
   endtask

   task automatic queue_frame(input int unsigned npix, input int unsigned ndrain);
      repeat (npix) queue_req(ACTION_PIXEL, rand_pix());
      repeat (ndrain) queue_req(ACTION_DRAIN, rand_pix());
   endtask

   // wait for every request to go in and every result to come out, then let the pipe empty
   task automatic settle();
      while (req_pending.size() != 0 || req_if.valid || blur_expected.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_size(input logic idx, input int unsigned value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_WIDTH'(value);
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == REG_FRAME_WIDTH) width_reg = CSR_WIDTH'(value);
      else height_reg = CSR_WIDTH'(value);
      restart_frame();
   endtask

   initial begin
      logic [23:0] corner [9];
      int unsigned random_items, w, h, total, drains_full, frames, kind, npix, ndr, pick;
      corner = '{24'h000000, 24'hFFFFFF, 24'h000000, 24'hFF00FF, 24'h00FF00,
                 24'hFFFFFF, 24'h0000FF, 24'hFFFF00, 24'hFFFFFF};
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.action   = ACTION_PIXEL;
      req_if.blue_in  = '0;
      req_if.green_in = '0;
      req_if.red_in   = '0;
      rsp_if.ready    = 1'b0;
      csr_write       = 1'b0;
      csr_index       = REG_FRAME_WIDTH;
      csr_wdata       = '0;
      req_fire        = 1'b0;
      rsp_fire        = 1'b0;
      send_gap        = 0;
      recv_gap        = 0;
      long_hold_left  = 0;
      long_hold_done  = 1'b0;
      send_quiet      = 1'b0;
      recv_quiet      = 1'b0;
      mismatch_count  = 0;
      stuck_cycles    = 0;
      width_reg       = RESET_WIDTH;
      height_reg      = RESET_HEIGHT;
      win             = '0;
      foreach (lines[i]) lines[i] = '0;
      restart_frame();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset sizes: drain with nothing pending, then a few pixels of row 0
      queue_req(ACTION_DRAIN, rand_pix());
      queue_frame(5, 0);
      settle();

      // 3x3 frame of saturated and empty channels, extra drain at the end
      write_size(REG_FRAME_WIDTH, 3);
      write_size(REG_FRAME_HEIGHT, 3);
      foreach (corner[i]) queue_req(ACTION_PIXEL, pix_type'(corner[i]));
      queue_frame(0, 7);
      settle();

      // zero sizes act as 1x1; pixel during drain drops the old frame
      write_size(REG_FRAME_WIDTH, 0);
      write_size(REG_FRAME_HEIGHT, 0);
      queue_req(ACTION_PIXEL, pix_type'(24'hFFFFFF));
      queue_frame(0, 2);
      queue_req(ACTION_PIXEL, pix_type'(24'h000000));
      queue_req(ACTION_PIXEL, pix_type'(24'hFFFFFF));
      queue_frame(0, 1);
      settle();

      // register write in mid-frame restarts it
      write_size(REG_FRAME_WIDTH, 4);
      write_size(REG_FRAME_HEIGHT, 4);
      queue_frame(11, 0);
      settle();
      write_size(REG_FRAME_HEIGHT, 4);
      queue_frame(0, 1);
      queue_frame(16, 3);
      queue_frame(16, 8);
      settle();

      random_items = 0;
      while (random_items < 420) begin
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         h = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
         if ($urandom_range(0, 24) == 0) w = 0;
         if ($urandom_range(0, 24) == 0) h = 0;
         pick = $urandom_range(0, 3);
         if (pick != 1) write_size(REG_FRAME_WIDTH, w);
         if (pick != 0) write_size(REG_FRAME_HEIGHT, h);
         w           = size_in_use(width_reg);
         h           = size_in_use(height_reg);
         total       = w * h;
         drains_full = w * ((h >= 2) ? 2 : 1);
         frames      = $urandom_range(1, 3);
         for (int f = 0; f < frames; f++) begin
            if ($urandom_range(0, 7) == 0) queue_req(ACTION_DRAIN, rand_pix());
            kind = $urandom_range(0, 9);
            npix = total;
            ndr  = drains_full;
            if (kind == 0) begin
               npix = $urandom_range(1, total);
               ndr  = (npix == total) ? $urandom_range(0, drains_full - 1) : 0;
            end else if (kind == 1) begin
               ndr = $urandom_range(0, drains_full - 1);
            end
            queue_frame(npix, ndr);
            if (kind == 2) queue_frame(0, $urandom_range(1, 2));
            random_items += npix + ndr;
            if (kind == 0) break;
         end
         settle();
      end

      settle();
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
